@@ design/hlbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hlbc_pkg
// Shared types, sizes and codes for the hashed LRU buffer cache directory.
// ----------------------------------------------------------------------------
package hlbc_pkg;

   // directory geometry
   localparam int NUM_BUFFERS = 32;
   localparam int NUM_BUCKETS = 13;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);

   // field widths
   localparam int MODE_W   = 2;
   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int BIDX_W   = 5;
   localparam int STATUS_W = 2;
   localparam int BUCKET_W = 4;
   localparam int COUNT_W  = 8;
   localparam int STAMP_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_COUNT_ERR = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [BIDX_W-1:0] buffer_index;
   } req_type;

   typedef struct packed {
      logic [BIDX_W-1:0]   entry;
      logic                hit;
      logic                need_disk_read;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // one directory entry
   typedef struct packed {
      logic [DEV_W-1:0]    tag_device;
      logic [BLK_W-1:0]    tag_block;
      logic [COUNT_W-1:0]  ref_count;
      logic                contents_valid;
      logic [BUCKET_W-1:0] bucket;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   // directory write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } wr_type;

endpackage

@@ design/hlbc_bucket_hash.sv @@
// ----------------------------------------------------------------------------
// hlbc_bucket_hash
// Iterative block number modulo NUM_BUCKETS, one nibble per cycle.
// ----------------------------------------------------------------------------
module hlbc_bucket_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hlbc_pkg::BLK_W-1:0]     block_number,
   output logic                           done,
   output logic [hlbc_pkg::BUCKET_W-1:0]  remainder
);
   import hlbc_pkg::*;

   localparam int STEPS = BLK_W / 4;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [BLK_W-1:0]    shift_ff;
   logic [BUCKET_W-1:0] rem_ff;
   logic [BUCKET_W-1:0] rem_in;
   logic [7:0]          partial;

   // restoring reduction of remainder * 16 + next nibble
   always_comb begin
      partial = {rem_ff, shift_ff[BLK_W-1 -: 4]};
      for (int s = 3; s >= 0; s--) begin
         if (partial >= 8'(NUM_BUCKETS << s)) begin
            partial = partial - 8'(NUM_BUCKETS << s);
         end
      end
      rem_in = partial[BUCKET_W-1:0];
   end

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= block_number;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[BLK_W-5:0], 4'b0000};
         rem_ff   <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ design/hlbc_entry_store.sv @@
// ----------------------------------------------------------------------------
// hlbc_entry_store
// Directory entries with one read port and one write port.
// ----------------------------------------------------------------------------
module hlbc_entry_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hlbc_pkg::IDX_W-1:0]    rd_idx,
   output hlbc_pkg::entry_type           rd_entry,
   input  hlbc_pkg::wr_type              wr
);
   import hlbc_pkg::*;

   entry_type entry_ff [NUM_BUFFERS];

   // reset puts every entry in bucket 0 with its index as stamp
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            entry_ff[i] <= {($bits(entry_type) - STAMP_W)'(0), STAMP_W'(i)};
         end
      end else if (wr.en) begin
         entry_ff[wr.idx] <= wr.data;
      end
   end

   assign rd_entry = entry_ff[rd_idx];

endmodule

@@ design/hashed_lru_buffer_cache.sv @@
// Read: hash of the block number, then a scan of every entry at one entry per
//   cycle, then a commit.
// Release, pin and unpin: an update state, then the registered response.
// One transaction in flight: a new request is taken only back in idle, once
//   the last one has committed; a stalled response holds back the commit.
// Synchronous reset restores the whole directory.
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache
// Buffer directory with hashed lookup, reference counts and LRU recycling.
// ----------------------------------------------------------------------------
module hashed_lru_buffer_cache (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hlbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hlbc_pkg::rsp_type rsp_data
);
   import hlbc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_HASH   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUFFERS - 1);

   logic [2:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [BUCKET_W-1:0] h_ff, h_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                match_vld_ff, match_vld_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic [STAMP_W-1:0]  match_stamp_ff, match_stamp_in;
   logic                free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [BUCKET_W-1:0] free_dist_ff, free_dist_in;
   logic [STAMP_W-1:0]  free_stamp_ff, free_stamp_in;
   logic [STAMP_W-1:0]  stamp_cnt_ff, stamp_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                hash_start;
   logic                hash_done;
   logic [BUCKET_W-1:0] hash_rem;
   logic [IDX_W-1:0]    rd_idx;
   entry_type           rd_entry;
   wr_type              wr;
   logic                out_free;
   logic [BUCKET_W:0]   dist_wide;
   logic [BUCKET_W-1:0] bkt_dist;
   logic                tag_match;
   logic [IDX_W-1:0]    pick;
   logic                in_range;

   hlbc_bucket_hash u_hash (
      .clock        (clock),
      .reset        (reset),
      .start        (hash_start),
      .block_number (req_data.block_number),
      .done         (hash_done),
      .remainder    (hash_rem)
   );

   hlbc_entry_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pick      = match_vld_ff ? match_idx_ff : free_idx_ff;
   assign in_range  = 32'(req_ff.buffer_index) < NUM_BUFFERS;

   // bucket distance from the read's bucket, wrapping round
   always_comb begin
      if (rd_entry.bucket >= h_ff) begin
         dist_wide = {1'b0, rd_entry.bucket} - {1'b0, h_ff};
      end else begin
         dist_wide = {1'b0, rd_entry.bucket} + (BUCKET_W+1)'(NUM_BUCKETS) - {1'b0, h_ff};
      end
      bkt_dist  = dist_wide[BUCKET_W-1:0];
      tag_match = (rd_entry.bucket == h_ff) && (rd_entry.tag_device == req_ff.device)
                  && (rd_entry.tag_block == req_ff.block_number);
   end

   // sequencer and shared compare unit
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      h_in           = h_ff;
      scan_idx_in    = scan_idx_ff;
      match_vld_in   = match_vld_ff;
      match_idx_in   = match_idx_ff;
      match_stamp_in = match_stamp_ff;
      free_vld_in    = free_vld_ff;
      free_idx_in    = free_idx_ff;
      free_dist_in   = free_dist_ff;
      free_stamp_in  = free_stamp_ff;
      stamp_cnt_in   = stamp_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      hash_start     = 1'b0;
      rd_idx         = scan_idx_ff;
      wr.en          = 1'b0;
      wr.idx         = rd_idx;
      wr.data        = rd_entry;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.mode == MODE_READ) begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end

         S_HASH: begin
            if (hash_done) begin
               h_in         = hash_rem;
               scan_idx_in  = '0;
               match_vld_in = 1'b0;
               free_vld_in  = 1'b0;
               state_in     = S_SCAN;
            end
         end

         // one entry per cycle: newest tag match, nearest-bucket oldest free
         S_SCAN: begin
            rd_idx = scan_idx_ff;
            if (tag_match && (!match_vld_ff || rd_entry.stamp > match_stamp_ff)) begin
               match_vld_in   = 1'b1;
               match_idx_in   = scan_idx_ff;
               match_stamp_in = rd_entry.stamp;
            end
            if ((rd_entry.ref_count == '0) && (!free_vld_ff || bkt_dist < free_dist_ff
                  || (bkt_dist == free_dist_ff && rd_entry.stamp < free_stamp_ff))) begin
               free_vld_in   = 1'b1;
               free_idx_in   = scan_idx_ff;
               free_dist_in  = bkt_dist;
               free_stamp_in = rd_entry.stamp;
            end
            if (scan_idx_ff == IDX_LAST) begin
               state_in = S_COMMIT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         S_COMMIT: begin
            rd_idx = pick;
            wr.idx = pick;
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.entry       = BIDX_W'(pick);
               rsp_in.hit         = match_vld_ff;
               rsp_in.status      = STATUS_OK;
               wr.data.contents_valid = 1'b1;
               if (match_vld_ff) begin
                  wr.en                 = 1'b1;
                  rsp_in.need_disk_read = !rd_entry.contents_valid;
                  if (rd_entry.ref_count == COUNT_MAX) begin
                     rsp_in.status = STATUS_COUNT_ERR;
                  end else begin
                     wr.data.ref_count = rd_entry.ref_count + 1'b1;
                  end
               end else if (free_vld_ff) begin
                  wr.en                 = 1'b1;
                  rsp_in.need_disk_read = 1'b1;
                  wr.data.tag_device    = req_ff.device;
                  wr.data.tag_block     = req_ff.block_number;
                  wr.data.ref_count     = COUNT_W'(1);
                  if (free_dist_ff != '0) begin
                     wr.data.bucket = h_ff;
                     wr.data.stamp  = stamp_cnt_ff;
                     stamp_cnt_in   = stamp_cnt_ff + 1'b1;
                  end
               end else begin
                  rsp_in.entry          = '0;
                  rsp_in.need_disk_read = 1'b0;
                  rsp_in.status         = STATUS_NO_FREE;
               end
               state_in = S_IDLE;
            end
         end

         // release, pin and unpin on one entry
         S_UPDATE: begin
            rd_idx = IDX_W'(req_ff.buffer_index);
            wr.idx = rd_idx;
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.entry          = req_ff.buffer_index;
               rsp_in.hit            = 1'b0;
               rsp_in.need_disk_read = 1'b0;
               rsp_in.status         = STATUS_OK;
               if (!in_range) begin
                  rsp_in.status = STATUS_COUNT_ERR;
               end else if (req_ff.mode == MODE_PIN) begin
                  if (rd_entry.ref_count == COUNT_MAX) begin
                     rsp_in.status = STATUS_COUNT_ERR;
                  end else begin
                     wr.en             = 1'b1;
                     wr.data.ref_count = rd_entry.ref_count + 1'b1;
                  end
               end else if (rd_entry.ref_count == '0) begin
                  rsp_in.status = STATUS_COUNT_ERR;
               end else begin
                  wr.en             = 1'b1;
                  wr.data.ref_count = rd_entry.ref_count - 1'b1;
                  if (req_ff.mode == MODE_RELEASE && rd_entry.ref_count == COUNT_W'(1)) begin
                     wr.data.stamp = stamp_cnt_ff;
                     stamp_cnt_in  = stamp_cnt_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         stamp_cnt_ff <= STAMP_W'(NUM_BUFFERS);
         match_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stamp_cnt_ff <= stamp_cnt_in;
         match_vld_ff <= match_vld_in;
         free_vld_ff  <= free_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      h_ff           <= h_in;
      scan_idx_ff    <= scan_idx_in;
      match_idx_ff   <= match_idx_in;
      match_stamp_ff <= match_stamp_in;
      free_idx_ff    <= free_idx_in;
      free_dist_ff   <= free_dist_in;
      free_stamp_ff  <= free_stamp_in;
      rsp_ff         <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/hlbc_checker.sv @@
// ----------------------------------------------------------------------------
// hlbc_checker
// Port-level checks for the buffer cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module hlbc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hlbc_pkg::rsp_type rsp_data
);
   import hlbc_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in progress");

   // no free buffer reports nothing else
   a_no_free_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NO_FREE
         |-> rsp_data.entry == '0 && !rsp_data.hit && !rsp_data.need_disk_read)
      else $error("no-free response carries entry data");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STATUS_OK || rsp_data.status == STATUS_NO_FREE
                    || rsp_data.status == STATUS_COUNT_ERR)
      else $error("undefined status code");

endmodule

bind hashed_lru_buffer_cache hlbc_checker u_hlbc_checker (.*);
